// ===== sv/jsonl_block_id_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block-id extractor
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JSONL_BLOCK_ID_EXTRACTOR_MACROS_SVH
`define JSONL_BLOCK_ID_EXTRACTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge
`define JBIE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent on the next edge
`define JBIE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define JBIE_ASSERT(lbl, prop)
`define JBIE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/jbie_pkg.sv =====
// ----------------------------------------------------------------------------
// jbie_pkg
// Shared types, constants and helper functions of the block-id extractor.
// ----------------------------------------------------------------------------
package jbie_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned AddrW      = 3;

	localparam logic [63:0] Golden = 64'h0000_0000_9E37_79B9;
	localparam logic [3:0]  KeyLen = 4'd10;

	// register index as seen in paddr[2]
	localparam logic RegHashMode = 1'b0;

	localparam logic [7:0] ChNul     = 8'h00;
	localparam logic [7:0] ChTab     = 8'h09;
	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChVtab    = 8'h0B;
	localparam logic [7:0] ChFfeed   = 8'h0C;
	localparam logic [7:0] ChCr      = 8'h0D;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChQuote   = 8'h22;
	localparam logic [7:0] ChComma   = 8'h2C;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;
	localparam logic [7:0] ChColon   = 8'h3A;
	localparam logic [7:0] ChLbrack  = 8'h5B;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_COLON,
		PH_BRACKET,
		PH_LIST,
		PH_BLANK,
		PH_SKIP
	} phase_t;

	// one queued command for the back end
	typedef struct packed {
		logic        start;   // list opened
		logic        close;   // element complete, value valid
		logic        fin;     // list ended
		logic [63:0] value;
	} evt_t;

	function automatic logic [7:0] key_char(input logic [3:0] pos);
		logic [7:0] ch;
		unique case (pos)
			4'd0:    ch = ChQuote;
			4'd1:    ch = 8'h68; // h
			4'd2:    ch = 8'h61; // a
			4'd3:    ch = 8'h73; // s
			4'd4:    ch = 8'h68; // h
			4'd5:    ch = 8'h5F; // _
			4'd6:    ch = 8'h69; // i
			4'd7:    ch = 8'h64; // d
			4'd8:    ch = 8'h73; // s
			4'd9:    ch = ChQuote;
			default: ch = ChNul;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChNine);
	endfunction

	function automatic logic is_pre_blank(input logic [7:0] c);
		return (c == ChTab) || (c == ChVtab) || (c == ChFfeed) || (c == ChCr);
	endfunction

	// acc*10 + digit, saturating at all ones
	function automatic logic [63:0] acc_step(input logic [63:0] acc, input logic [7:0] c);
		logic [67:0] prod;
		prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, c[3:0]};
		return (|prod[67:64]) ? {64{1'b1}} : prod[63:0];
	endfunction

	function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [63:0] v);
		return h ^ (v + Golden + {h[57:0], 6'd0} + {2'd0, h[63:2]});
	endfunction

endpackage

// ===== sv/jbie_front.sv =====
// ----------------------------------------------------------------------------
// jbie_front
// Byte classifier and line parser: key search, list syntax and decimal
// accumulation. Emits start/close/end commands toward the back end.
// ----------------------------------------------------------------------------
module jbie_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           char_byte,
	input  logic                 end_of_trace,
	output logic                 push,
	output jbie_pkg::evt_t       ev
);

	jbie_pkg::phase_t phase_q, phase_d;
	logic [3:0]  key_pos_q, key_pos_d;
	logic [63:0] acc_q, acc_d;
	logic        digit_q, digit_d;

	logic       eol;
	logic       c_digit, c_pre, c_space;
	logic       key_hit;

	assign eol     = end_of_trace || (char_byte == jbie_pkg::ChNewline);
	assign c_digit = jbie_pkg::is_digit(char_byte);
	assign c_pre   = jbie_pkg::is_pre_blank(char_byte);
	assign c_space = (char_byte == jbie_pkg::ChSpace);
	assign key_hit = (char_byte == jbie_pkg::key_char(key_pos_q));

	// next state
	always_comb begin
		phase_d = phase_q;
		if (eol) begin
			phase_d = jbie_pkg::PH_SEARCH;
		end else begin
			unique case (phase_q)
				jbie_pkg::PH_SEARCH: begin
					if (char_byte == jbie_pkg::ChNul)
						phase_d = jbie_pkg::PH_SKIP;
					else if (key_hit && key_pos_q == jbie_pkg::KeyLen - 4'd1)
						phase_d = jbie_pkg::PH_COLON;
				end
				jbie_pkg::PH_COLON: begin
					if (char_byte == jbie_pkg::ChColon)
						phase_d = jbie_pkg::PH_BRACKET;
					else if (!(c_space || char_byte == jbie_pkg::ChTab))
						phase_d = jbie_pkg::PH_SKIP;
				end
				jbie_pkg::PH_BRACKET: begin
					if (char_byte == jbie_pkg::ChLbrack)
						phase_d = jbie_pkg::PH_LIST;
					else if (!(c_space || char_byte == jbie_pkg::ChTab))
						phase_d = jbie_pkg::PH_SKIP;
				end
				jbie_pkg::PH_LIST: begin
					priority if (digit_q && c_digit)
						phase_d = jbie_pkg::PH_LIST;
					else if (c_space || char_byte == jbie_pkg::ChComma)
						phase_d = jbie_pkg::PH_LIST;
					else if (c_pre)
						phase_d = jbie_pkg::PH_BLANK;
					else if (c_digit)
						phase_d = jbie_pkg::PH_LIST;
					else
						phase_d = jbie_pkg::PH_SKIP;
				end
				jbie_pkg::PH_BLANK: begin
					if (c_digit)
						phase_d = jbie_pkg::PH_LIST;
					else if (!(c_space || c_pre))
						phase_d = jbie_pkg::PH_SKIP;
				end
				jbie_pkg::PH_SKIP: phase_d = jbie_pkg::PH_SKIP;
				default:           phase_d = jbie_pkg::PH_SKIP;
			endcase
		end
	end

	// outputs and datapath
	always_comb begin
		ev        = '0;
		key_pos_d = key_pos_q;
		acc_d     = acc_q;
		digit_d   = digit_q;
		if (eol) begin
			if (phase_q == jbie_pkg::PH_LIST || phase_q == jbie_pkg::PH_BLANK) begin
				ev.close = digit_q;
				ev.value = acc_q;
				ev.fin   = 1'b1;
			end
			key_pos_d = '0;
			acc_d     = '0;
			digit_d   = 1'b0;
		end else begin
			unique case (phase_q)
				jbie_pkg::PH_SEARCH: begin
					if (char_byte != jbie_pkg::ChNul) begin
						if (key_hit)
							key_pos_d = (key_pos_q == jbie_pkg::KeyLen - 4'd1) ?
								4'd0 : key_pos_q + 4'd1;
						else
							key_pos_d = (char_byte == jbie_pkg::ChQuote) ? 4'd1 : 4'd0;
					end
				end
				jbie_pkg::PH_BRACKET: begin
					if (char_byte == jbie_pkg::ChLbrack) begin
						ev.start = 1'b1;
						acc_d    = '0;
						digit_d  = 1'b0;
					end
				end
				jbie_pkg::PH_LIST: begin
					if (digit_q && c_digit) begin
						acc_d = jbie_pkg::acc_step(acc_q, char_byte);
					end else begin
						if (digit_q) begin
							ev.close = 1'b1;
							ev.value = acc_q;
							acc_d    = '0;
							digit_d  = 1'b0;
						end
						priority if (c_space || char_byte == jbie_pkg::ChComma || c_pre) begin
							// separator or leading blank
						end else if (c_digit) begin
							acc_d   = jbie_pkg::acc_step('0, char_byte);
							digit_d = 1'b1;
						end else begin
							ev.fin = 1'b1;
						end
					end
				end
				jbie_pkg::PH_BLANK: begin
					if (c_digit) begin
						acc_d   = jbie_pkg::acc_step('0, char_byte);
						digit_d = 1'b1;
					end else if (!(c_space || c_pre)) begin
						ev.fin = 1'b1;
					end
				end
				jbie_pkg::PH_COLON, jbie_pkg::PH_SKIP: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign push = accept && (ev.start || ev.close || ev.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= jbie_pkg::PH_SEARCH;
			key_pos_q <= '0;
			acc_q     <= '0;
			digit_q   <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			key_pos_q <= key_pos_d;
			acc_q     <= acc_d;
			digit_q   <= digit_d;
		end
	end

endmodule

// ===== sv/jbie_fifo.sv =====
// ----------------------------------------------------------------------------
// jbie_fifo
// Small command queue between the parser and the id/hash back end.
// ----------------------------------------------------------------------------
`include "jsonl_block_id_extractor_macros.svh"

module jbie_fifo #(
	parameter int unsigned Depth = jbie_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jbie_pkg::evt_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output jbie_pkg::evt_t head_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	jbie_pkg::evt_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`JBIE_ASSERT(a_no_push_full, !(push && full))
	`JBIE_ASSERT(a_no_pop_empty, !(pop && !head_valid))
	`JBIE_ASSERT(a_count_bound, count_q <= CntW'(Depth))

endmodule

// ===== sv/jbie_back.sv =====
// ----------------------------------------------------------------------------
// jbie_back
// Executes queued commands: rolling hash, one-element hold-back for the
// last-block mark, request counter, and the output register.
// ----------------------------------------------------------------------------
`include "jsonl_block_id_extractor_macros.svh"

module jbie_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hash_mode,
	input  logic           head_valid,
	input  jbie_pkg::evt_t head_data,
	output logic           pop,
	output logic           block_valid,
	input  logic           block_stall,
	output logic [63:0]    block_id,
	output logic [31:0]    request_index,
	output logic           last_block
);

	logic [63:0] hash_q;
	logic        first_q;
	logic [63:0] pend_q;
	logic        pend_valid_q;
	logic [31:0] count_q;
	logic        close_done_q;

	logic        out_valid_q;
	logic [63:0] out_id_q;
	logic [31:0] out_req_q;
	logic        out_last_q;

	logic        adv, do_start, do_close, do_fin, emit;
	logic [63:0] hash_next, id;

	assign adv      = head_valid && (!out_valid_q || !block_stall);
	assign do_start = head_data.start;
	assign do_close = !head_data.start && head_data.close && !close_done_q;
	assign do_fin   = !head_data.start && !do_close && head_data.fin;
	assign emit     = adv && (do_close || do_fin) && pend_valid_q;
	// an element that also ends the list takes a second pass
	assign pop      = adv && !(do_close && head_data.fin);

	assign hash_next = first_q ? head_data.value : jbie_pkg::hash_step(hash_q, head_data.value);
	assign id        = hash_mode ? hash_next : head_data.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q       <= '0;
			first_q      <= 1'b1;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			count_q      <= '0;
			close_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!block_stall)
				out_valid_q <= 1'b0;
			if (adv) begin
				if (do_start) begin
					hash_q       <= '0;
					first_q      <= 1'b1;
					pend_valid_q <= 1'b0;
				end else if (do_close) begin
					if (hash_mode)
						hash_q <= hash_next;
					first_q      <= 1'b0;
					pend_q       <= id;
					pend_valid_q <= 1'b1;
					close_done_q <= head_data.fin;
				end else begin
					close_done_q <= 1'b0;
					if (pend_valid_q) begin
						count_q      <= count_q + 32'd1;
						pend_valid_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_id_q   <= pend_q;
			out_req_q  <= count_q;
			out_last_q <= do_fin;
		end
	end

	assign block_valid   = out_valid_q;
	assign block_id      = out_id_q;
	assign request_index = out_req_q;
	assign last_block    = out_last_q;

	`JBIE_ASSERT_NEXT(a_fin_clears_pending, adv && do_fin && pend_valid_q,
		!pend_valid_q && out_valid_q && out_last_q)
	`JBIE_ASSERT_NEXT(a_close_sets_pending, adv && do_close, pend_valid_q)
	`JBIE_ASSERT(a_split_entry_held, !close_done_q || head_valid)

endmodule

// ===== sv/jsonl_block_id_extractor.sv =====
// ----------------------------------------------------------------------------
// jsonl_block_id_extractor
// Extracts the id list elements from a line-oriented JSON byte stream.
// ----------------------------------------------------------------------------
// The block takes one trace byte per cycle, sustained, as long as its
// command queue has room. Each byte is parsed by the front parser; list
// events go through a queue of QueueDepth entries to the back end, which
// runs one 64-bit hash combine per cycle while the output is not stalled
// and holds back one id so the last id of each request carries last_block.
// An element that closes together with its list takes a close pass and an
// end pass in the back end; results wait while the output is stalled.
// hash_mode sits at byte address 0 (bit 0, reset 1) and should only be
// written while the block is idle.
module jsonl_block_id_extractor #(
	parameter int unsigned QueueDepth = jbie_pkg::QueueDepth
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         byte_valid,
	output logic                         byte_stall,
	input  logic [7:0]                   char_byte,
	input  logic                         end_of_trace,

	output logic                         block_valid,
	input  logic                         block_stall,
	output logic [63:0]                  block_id,
	output logic [31:0]                  request_index,
	output logic                         last_block,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [jbie_pkg::AddrW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic           hash_mode_q;
	logic           accept;
	logic           push, full, pop, head_valid;
	jbie_pkg::evt_t ev, head_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == jbie_pkg::RegHashMode) ? {31'd0, hash_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hash_mode_q <= 1'b1;
		else if (psel && penable && pwrite && pready && paddr[2] == jbie_pkg::RegHashMode)
			hash_mode_q <= pwdata[0];
	end

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	jbie_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_byte    (char_byte),
		.end_of_trace (end_of_trace),
		.push         (push),
		.ev           (ev)
	);

	jbie_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (ev),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	jbie_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.hash_mode     (hash_mode_q),
		.head_valid    (head_valid),
		.head_data     (head_data),
		.pop           (pop),
		.block_valid   (block_valid),
		.block_stall   (block_stall),
		.block_id      (block_id),
		.request_index (request_index),
		.last_block    (last_block)
	);

endmodule
